// ===== rtl/uart_line_assembler_queue_defines.svh =====
// ============================================================================
// uart_line_assembler_queue_defines
// Assertion macros shared by the line assembler RTL. In synthesis builds
// the macros expand to nothing.
// ============================================================================
`ifndef UART_LINE_ASSEMBLER_QUEUE_DEFINES_SVH
`define UART_LINE_ASSEMBLER_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ULAQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define ULAQ_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ULAQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define ULAQ_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/ulaq_pkg.sv =====
// ============================================================================
// ulaq_pkg
// Shared types and constants of the UART line assembler and message queue.
// ============================================================================
`default_nettype none

package ulaq_pkg;

    // Default geometry.
    localparam int MSG_LEN_DEF     = 64;
    localparam int QUEUE_SLOTS_DEF = 8;

    // Action codes of an input word.
    localparam logic [1:0] ACT_RX      = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;

    // Line editing characters.
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;

    // Saturation limit of the overflow counter.
    localparam logic [15:0] OVF_MAX = 16'hFFFF;

    // Event codes reported with each result word.
    typedef enum logic [2:0] {
        EV_APPEND    = 3'd0,
        EV_BACKSPACE = 3'd1,
        EV_QUEUED    = 3'd2,
        EV_OVERRUN   = 3'd3,
        EV_OVERFLOW  = 3'd4,
        EV_READ      = 3'd5,
        EV_RELEASED  = 3'd6,
        EV_NONE      = 3'd7
    } t_event;

    // Per-item result fields that do not come from the counters.
    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        t_event     event_res;
        logic [7:0] read_byte;
    } t_result;

    // Write enables into the message store.
    typedef struct packed {
        logic ring_we;
        logic slen_we;
    } t_ring_ctl;

endpackage

`default_nettype wire

// ===== rtl/uart_line_assembler_queue.sv =====
// ============================================================================
// uart_line_assembler_queue
// Line editor for received UART bytes that commits finished lines to a ring
// of message slots, read and released by a consumer.
// ============================================================================
// Usage:
// The input channel carries one word per action: a received byte, a read of
// one byte of the oldest message, or a release of the oldest message. Every
// accepted word gives exactly one result word on the output channel with the
// echo, an event code, the read byte and both counters after the action.
// Items are handled one at a time; o_stall is high while an item is at work.
// Most words go from acceptance straight to the result stage; a read also
// waits on the registered read port of the message memory. Committing a
// line of N bytes copies it from the line memory into the ring memory, one
// byte a cycle, through the single ring write port; this copy sets the
// worst case of the time an item takes.
// The result sits in an output register; the next item is accepted while a
// stalled result waits, and its own result is held until the output is free.
// Synchronous reset empties the line and the queue and clears the counters;
// no memory clearing pass is needed.
// ============================================================================
`default_nettype none

`include "uart_line_assembler_queue_defines.svh"

module uart_line_assembler_queue #(
    parameter int MSG_LEN     = ulaq_pkg::MSG_LEN_DEF,
    parameter int QUEUE_SLOTS = ulaq_pkg::QUEUE_SLOTS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Input channel
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire [1:0]                           i_action,
    input  wire [7:0]                           i_rx_byte,
    input  wire [$clog2(MSG_LEN)-1:0]           i_read_offset,
    // Output channel
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic                                o_echo_valid,
    output logic [7:0]                          o_echo_byte,
    output logic [2:0]                          o_event_res,
    output logic [7:0]                          o_read_byte,
    output logic [$clog2(QUEUE_SLOTS+1)-1:0]    o_messages_waiting,
    output logic [15:0]                         o_overflow_count
);

    localparam int LW  = $clog2(MSG_LEN);
    localparam int SW  = $clog2(QUEUE_SLOTS);
    localparam int CW  = $clog2(QUEUE_SLOTS+1);
    localparam int RAW = $clog2(QUEUE_SLOTS*MSG_LEN);

    localparam logic [LW-1:0]  LINE_MAX  = LW'(MSG_LEN - 1);
    localparam logic [SW-1:0]  LAST_SLOT = SW'(QUEUE_SLOTS - 1);
    localparam logic [RAW-1:0] MSG_STEP  = RAW'(MSG_LEN);
    localparam logic [CW-1:0]  WAIT_MAX  = CW'(QUEUE_SLOTS);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_COPY = 5'b00010,
        S_CEND = 5'b00100,
        S_RD   = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    // Control state
    t_state           r_state,    n_state;
    logic [LW-1:0]    r_line_len, n_line_len;
    logic [SW-1:0]    r_wr_slot,  n_wr_slot;
    logic [SW-1:0]    r_rd_slot,  n_rd_slot;
    logic [RAW-1:0]   r_wr_base,  n_wr_base;
    logic [RAW-1:0]   r_rd_base,  n_rd_base;
    logic [CW-1:0]    r_wait,     n_wait;
    logic [15:0]      r_ovf,      n_ovf;
    logic             r_cp_vld,   n_cp_vld;
    logic             r_out_vld,  n_out_vld;

    // Working registers
    logic [LW-1:0]    r_cnt,      n_cnt;
    logic [RAW-1:0]   r_cp_ptr,   n_cp_ptr;
    logic [LW-1:0]    r_off,      n_off;
    ulaq_pkg::t_result r_res,     n_res;
    ulaq_pkg::t_result r_out;
    logic [CW-1:0]    r_out_wait;
    logic [15:0]      r_out_ovf;

    // Memory interfaces
    logic [7:0]       line_mem [MSG_LEN];
    logic [7:0]       r_line_q;
    logic             line_we;
    ulaq_pkg::t_ring_ctl ring_ctl;
    logic [7:0]       ring_rdata;
    logic [LW-1:0]    slen_rdata;

    logic             in_acc;
    logic             out_load;
    logic             commit_fin;
    logic             line_full;
    logic             is_eol;
    logic             is_bs;
    logic [SW-1:0]    wr_slot_adv;

    assign in_acc    = i_valid && !o_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign out_load  = (r_state == S_FIN) && (!r_out_vld || !i_stall);
    assign line_full = (r_line_len == LINE_MAX);
    assign is_eol    = (i_rx_byte == ulaq_pkg::CH_LF) || (i_rx_byte == ulaq_pkg::CH_CR);
    assign is_bs     = (i_rx_byte == ulaq_pkg::CH_BS) || (i_rx_byte == ulaq_pkg::CH_DEL);
    assign wr_slot_adv = (r_wr_slot == LAST_SLOT) ? '0 : r_wr_slot + 1'b1;

    // Line memory: written on append, read by the commit copy.
    always_ff @(posedge i_clk) begin
        if (line_we) begin
            line_mem[r_line_len] <= i_rx_byte;
        end
        r_line_q <= line_mem[r_cnt];
    end

    // Ring and slot length memories.
    ulaq_ring #(
        .MSG_LEN     (MSG_LEN),
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_ring (
        .i_clk        (i_clk),
        .i_ctl        (ring_ctl),
        .i_ring_waddr (r_cp_ptr),
        .i_ring_wdata (r_line_q),
        .i_ring_raddr (r_rd_base + RAW'(i_read_offset)),
        .o_ring_rdata (ring_rdata),
        .i_slen_waddr (r_wr_slot),
        .i_slen_wdata (r_line_len),
        .i_slen_raddr (r_rd_slot),
        .o_slen_rdata (slen_rdata)
    );

    // Sequencer and next-state logic.
    always_comb begin
        n_state          = r_state;
        n_line_len       = r_line_len;
        n_wr_slot        = r_wr_slot;
        n_rd_slot        = r_rd_slot;
        n_wr_base        = r_wr_base;
        n_rd_base        = r_rd_base;
        n_wait           = r_wait;
        n_ovf            = r_ovf;
        n_cp_vld         = 1'b0;
        n_cnt            = r_cnt;
        n_cp_ptr         = r_cp_ptr;
        n_off            = r_off;
        n_res            = r_res;
        line_we          = 1'b0;
        ring_ctl.ring_we = r_cp_vld;
        ring_ctl.slen_we = 1'b0;
        commit_fin       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res.echo_valid = (i_action == ulaq_pkg::ACT_RX);
                    n_res.echo_byte  = (i_action == ulaq_pkg::ACT_RX) ? i_rx_byte : 8'd0;
                    n_res.event_res  = ulaq_pkg::EV_NONE;
                    n_res.read_byte  = 8'd0;
                    n_state          = S_FIN;
                    priority if (i_action == ulaq_pkg::ACT_RX) begin
                        priority if (line_full) begin
                            // Overlong line: drop it and count it.
                            n_line_len      = '0;
                            n_res.event_res = ulaq_pkg::EV_OVERFLOW;
                            if (r_ovf != ulaq_pkg::OVF_MAX) begin
                                n_ovf = r_ovf + 16'd1;
                            end
                        end else if (is_eol) begin
                            // Commit: record the length, then copy if not empty.
                            ring_ctl.slen_we = 1'b1;
                            if (r_line_len == '0) begin
                                commit_fin = 1'b1;
                            end else begin
                                n_cnt   = '0;
                                n_state = S_COPY;
                            end
                        end else if (is_bs) begin
                            if (r_line_len != '0) begin
                                n_line_len = r_line_len - 1'b1;
                            end
                            n_res.event_res = ulaq_pkg::EV_BACKSPACE;
                        end else begin
                            line_we         = 1'b1;
                            n_line_len      = r_line_len + 1'b1;
                            n_res.event_res = ulaq_pkg::EV_APPEND;
                        end
                    end else if (i_action == ulaq_pkg::ACT_READ) begin
                        if (r_wait != '0) begin
                            n_off   = i_read_offset;
                            n_state = S_RD;
                        end
                    end else if (i_action == ulaq_pkg::ACT_RELEASE) begin
                        if (r_wait != '0) begin
                            n_rd_slot       = (r_rd_slot == LAST_SLOT) ? '0 : r_rd_slot + 1'b1;
                            n_rd_base       = (r_rd_slot == LAST_SLOT) ? '0
                                                                       : r_rd_base + MSG_STEP;
                            n_wait          = r_wait - 1'b1;
                            n_res.event_res = ulaq_pkg::EV_RELEASED;
                        end
                    end else begin
                        n_res.event_res = ulaq_pkg::EV_NONE;
                    end
                end
            end
            S_COPY: begin
                // Issue one line read; its ring write follows in the next cycle.
                n_cp_vld = 1'b1;
                n_cp_ptr = r_wr_base + RAW'(r_cnt);
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == r_line_len - 1'b1) begin
                    n_state = S_CEND;
                end
            end
            S_CEND: begin
                // Last ring write is in flight; close the commit.
                commit_fin = 1'b1;
                n_state    = S_FIN;
            end
            S_RD: begin
                n_res.event_res = ulaq_pkg::EV_READ;
                n_res.read_byte = (r_off < slen_rdata) ? ring_rdata : 8'd0;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Line commit: clear the line, advance the write slot, count the message and report queued or overrun.
        if (commit_fin) begin
            n_line_len      = '0;
            n_wr_slot       = wr_slot_adv;
            n_wr_base       = (r_wr_slot == LAST_SLOT) ? '0 : r_wr_base + MSG_STEP;
            n_res.event_res = (wr_slot_adv == r_rd_slot) ? ulaq_pkg::EV_OVERRUN
                                                         : ulaq_pkg::EV_QUEUED;
            if (r_wait != WAIT_MAX) begin
                n_wait = r_wait + 1'b1;
            end
        end
    end

    // Output register valid.
    always_comb begin
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (!i_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_line_len <= '0;
            r_wr_slot  <= '0;
            r_rd_slot  <= '0;
            r_wr_base  <= '0;
            r_rd_base  <= '0;
            r_wait     <= '0;
            r_ovf      <= '0;
            r_cp_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_line_len <= n_line_len;
            r_wr_slot  <= n_wr_slot;
            r_rd_slot  <= n_rd_slot;
            r_wr_base  <= n_wr_base;
            r_rd_base  <= n_rd_base;
            r_wait     <= n_wait;
            r_ovf      <= n_ovf;
            r_cp_vld   <= n_cp_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_cp_ptr <= n_cp_ptr;
        r_off    <= n_off;
        r_res    <= n_res;
        if (out_load) begin
            r_out      <= r_res;
            r_out_wait <= r_wait;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_valid            = r_out_vld;
    assign o_echo_valid       = r_out.echo_valid;
    assign o_echo_byte        = r_out.echo_byte;
    assign o_event_res        = r_out.event_res;
    assign o_read_byte        = r_out.read_byte;
    assign o_messages_waiting = r_out_wait;
    assign o_overflow_count   = r_out_ovf;

    // Checks on the queue bookkeeping and the copy sequencer.
    `ULAQ_NEVER(a_wait_bound, i_clk, i_rst_n, r_wait > WAIT_MAX, "waiting count above slot count")
    `ULAQ_NEVER(a_line_bound, i_clk, i_rst_n, r_line_len > LINE_MAX, "line length out of range")
    `ULAQ_ASSERT(a_ring_wr_copy, i_clk, i_rst_n, r_cp_vld |-> (r_state == S_COPY || r_state == S_CEND), "ring write outside a commit copy")
    `ULAQ_ASSERT(a_accept_busy, i_clk, i_rst_n, in_acc |=> (r_state != S_IDLE), "accepted word left no work")

endmodule

`default_nettype wire

// ===== rtl/ulaq_ring.sv =====
// ============================================================================
// ulaq_ring
// Message store: the byte ring of all slots and the length of each slot,
// both as synchronous memories with one write and one registered read port.
// ============================================================================
`default_nettype none

module ulaq_ring #(
    parameter int MSG_LEN     = ulaq_pkg::MSG_LEN_DEF,
    parameter int QUEUE_SLOTS = ulaq_pkg::QUEUE_SLOTS_DEF
) (
    input  wire                                   i_clk,
    input  ulaq_pkg::t_ring_ctl                   i_ctl,
    input  wire [$clog2(QUEUE_SLOTS*MSG_LEN)-1:0] i_ring_waddr,
    input  wire [7:0]                             i_ring_wdata,
    input  wire [$clog2(QUEUE_SLOTS*MSG_LEN)-1:0] i_ring_raddr,
    output logic [7:0]                            o_ring_rdata,
    input  wire [$clog2(QUEUE_SLOTS)-1:0]         i_slen_waddr,
    input  wire [$clog2(MSG_LEN)-1:0]             i_slen_wdata,
    input  wire [$clog2(QUEUE_SLOTS)-1:0]         i_slen_raddr,
    output logic [$clog2(MSG_LEN)-1:0]            o_slen_rdata
);

    localparam int LW = $clog2(MSG_LEN);

    logic [7:0]    ring_mem [QUEUE_SLOTS*MSG_LEN];
    logic [LW-1:0] slen_mem [QUEUE_SLOTS];

    // Byte ring: one write, one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ring_we) begin
            ring_mem[i_ring_waddr] <= i_ring_wdata;
        end
        o_ring_rdata <= ring_mem[i_ring_raddr];
    end

    // Slot lengths: one write, one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.slen_we) begin
            slen_mem[i_slen_waddr] <= i_slen_wdata;
        end
        o_slen_rdata <= slen_mem[i_slen_raddr];
    end

endmodule

`default_nettype wire
